FILE: hdl/transient_envelope_boost_unit_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef TRANSIENT_ENVELOPE_BOOST_UNIT_MACROS_SVH
`define TRANSIENT_ENVELOPE_BOOST_UNIT_MACROS_SVH

// Same-cycle implication.
`define TEBU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("transient_envelope_boost_unit: assertion failed");

// Next-cycle implication.
`define TEBU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("transient_envelope_boost_unit: assertion failed");

`endif

FILE: hdl/tebu_pkg.sv
package tebu_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_W = 24;
	localparam int BOOST_W = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [COEF_W-1:0] FAST_ATTACK_RST = 24'd924600;
	localparam logic [COEF_W-1:0] FAST_RELEASE_RST = 24'd31680;
	localparam logic [COEF_W-1:0] SLOW_ATTACK_RST = 24'd4755;
	localparam logic [COEF_W-1:0] SLOW_RELEASE_RST = 24'd1902;
	localparam logic [BOOST_W-1:0] MAX_BOOST_RST = 12'd0;

	// Mask is Q1.24 and reaches exactly one.
	localparam int MASK_W = 25;
	localparam logic [MASK_W-1:0] MASK_ONE = 25'h1000000;
	// ln(10)/20 in Q0.28.
	localparam int LN_W = 25;
	localparam logic [LN_W-1:0] LN10_OVER_20_Q28 = 25'd30904774;
	localparam int Y_W = 30;
	localparam logic [Y_W-1:0] ONE_Q28 = 30'h10000000;
	localparam int GAIN_W = 31;
	localparam int SERIES_TERMS = 20;
	localparam int TERM_IDX_W = 5;

	// Shared bit-serial arithmetic units.
	localparam int MUL_AW = 37;
	localparam int MUL_BW = 32;
	localparam int DIV_QW = 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST_ATTACK = 3'd0,
		CFG_FAST_RELEASE = 3'd1,
		CFG_SLOW_ATTACK = 3'd2,
		CFG_SLOW_RELEASE = 3'd3,
		CFG_MAX_BOOST = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

FILE: hdl/tebu_smul.sv
module tebu_smul #(
	parameter int AW = tebu_pkg::MUL_AW,
	parameter int BW = tebu_pkg::MUL_BW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [AW-1:0]        a,
	input  logic [BW-1:0]        b,
	output tebu_pkg::unit_stat_t stat,
	output logic [AW+BW-1:0]     prod
);
	localparam int CW = $clog2(BW + 1);

	logic [AW-1:0] a_q;
	logic [AW+BW-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [AW:0] sum;

	// The multiplier sits in the low half and is consumed LSB first.
	assign sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			a_q <= '0;
			p_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q <= a;
				p_q <= {{AW{1'b0}}, b};
				cnt_q <= CW'(BW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				p_q <= {sum, p_q[BW-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod = p_q;
endmodule

FILE: hdl/tebu_sdiv.sv
module tebu_sdiv #(
	parameter int DW = tebu_pkg::SAMPLE_BITS_DEF + 3,
	parameter int QW = tebu_pkg::DIV_QW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        rem0,
	input  logic [QW-1:0]        lo,
	input  logic [DW-1:0]        dvsr,
	output tebu_pkg::unit_stat_t stat,
	output logic [QW-1:0]        quot
);
	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q, dvsr_q;
	logic [QW-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DW:0] trial, diff;
	logic ge;

	// Restoring division: the partial remainder stays below the divisor.
	assign trial = {rem_q, lo_q[QW-1]};
	assign ge = trial >= {1'b0, dvsr_q};
	assign diff = trial - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dvsr_q <= '0;
			lo_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= rem0;
				lo_q <= lo;
				dvsr_q <= dvsr;
				cnt_q <= CW'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				lo_q <= {lo_q[QW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot = lo_q;
endmodule

FILE: hdl/transient_envelope_boost_unit.sv
// Stereo transient shaper: the low-band magnitudes drive fast and slow
// envelopes, their difference sets a boost mask, and the gain minus one,
// exp(max_boost * ln10/20 * mask) - 1, is applied to the low band and added
// to the full-band sample with saturation. One sample pair is worked on at
// a time. The 20-term gain series runs on one bit-serial multiplier and one
// bit-serial divider (one bit per cycle each); it is skipped when the fast
// envelope does not exceed the slow one, and with max_boost_db at zero the
// full-band samples pass through. A finished result waits in the output
// register while the next transaction is accepted. Configuration writes are
// always ready and must only be issued while no transaction is in flight.
`include "transient_envelope_boost_unit_macros.svh"

module transient_envelope_boost_unit #(
	parameter int SAMPLE_BITS = tebu_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tebu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tebu_pkg::COEF_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_BITS-1:0]  full_left,
	input  logic signed [SAMPLE_BITS-1:0]  full_right,
	input  logic signed [SAMPLE_BITS-1:0]  low_left,
	input  logic signed [SAMPLE_BITS-1:0]  low_right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]  out_left,
	output logic signed [SAMPLE_BITS-1:0]  out_right
);
	localparam int W = SAMPLE_BITS;
	localparam int AW = tebu_pkg::MUL_AW;
	localparam int BW = tebu_pkg::MUL_BW;
	localparam int PW = AW + BW;
	localparam int QW = tebu_pkg::DIV_QW;
	localparam int DW = W + 3;
	localparam int NW = W + 28;
	localparam int GW = tebu_pkg::GAIN_W;
	localparam int YW = tebu_pkg::Y_W;
	localparam int TW = tebu_pkg::TERM_IDX_W;
	localparam logic [W-1:0] ENV_MAX = W'(1) << (W - 1);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_ENV    = 11'b000_0000_0010,
		ST_ENV_W  = 11'b000_0000_0100,
		ST_SUM    = 11'b000_0000_1000,
		ST_MASK_W = 11'b000_0001_0000,
		ST_P_W    = 11'b000_0010_0000,
		ST_Y_W    = 11'b000_0100_0000,
		ST_TM_W   = 11'b000_1000_0000,
		ST_TD_W   = 11'b001_0000_0000,
		ST_BST    = 11'b010_0000_0000,
		ST_BST_W  = 11'b100_0000_0000
	} state_t;

	// Result is always parked here first and moves on once the output register is free or draining.
	logic res_pend_q;

	state_t state_q;
	logic [tebu_pkg::COEF_W-1:0] fa_q, fr_q, sa_q, sr_q;
	logic [tebu_pkg::BOOST_W-1:0] mb_q;
	logic [W-1:0] env_q [4];
	logic [W-1:0] full_l_q, full_r_q, low_l_q, low_r_q;
	logic [W-1:0] res_l_q, res_r_q, out_l_q, out_r_q;
	logic out_valid_q;
	logic [1:0] k_q;
	logic up_q, ch_q;
	logic [YW-1:0] y_q;
	logic [GW-1:0] gm1_q;
	logic [TW-1:0] n_q;

	logic mul_go_q, div_go_q;
	logic [AW-1:0] mul_a_q;
	logic [BW-1:0] mul_b_q;
	logic [DW-1:0] div_rem0_q, div_dvsr_q;
	logic [QW-1:0] div_lo_q;
	tebu_pkg::unit_stat_t mul_st, div_st;
	logic [PW-1:0] prod;
	logic [QW-1:0] quot;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [W-1:0] sat(input logic [W+3:0] r);
		logic [W-1:0] res;
		res = r[W-1:0];
		if (!r[W+3] && (r[W+2:W-1] != '0))
			res = {1'b0, {(W-1){1'b1}}};
		else if (r[W+3] && (r[W+2:W-1] != '1))
			res = {1'b1, {(W-1){1'b0}}};
		return res;
	endfunction

	tebu_smul #(.AW(AW), .BW(BW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.stat(mul_st), .prod(prod)
	);

	tebu_sdiv #(.DW(DW), .QW(QW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .rem0(div_rem0_q), .lo(div_lo_q),
		.dvsr(div_dvsr_q), .stat(div_st), .quot(quot)
	);

	// Envelope step operands.
	logic [W-1:0] m_cur, e_cur, r_env;
	logic up_cur;
	assign m_cur = mag(k_q[0] ? low_r_q : low_l_q);
	assign e_cur = env_q[k_q];
	assign up_cur = m_cur > e_cur;
	assign r_env = W'(prod[W+23:24]) + W'(prod[23]);

	// Mask operands.
	logic [W:0] f_sum, s_sum, d_sum;
	logic [DW-1:0] d5, den;
	logic [NW-1:0] num;
	assign f_sum = (W+1)'(env_q[0]) + (W+1)'(env_q[1]);
	assign s_sum = (W+1)'(env_q[2]) + (W+1)'(env_q[3]);
	assign d_sum = f_sum - s_sum;
	assign d5 = (DW'(d_sum) << 2) + DW'(d_sum);
	assign den = d5 + (DW'(s_sum) << 1);
	assign num = {d5, 24'b0} + NW'(den >> 1);

	// Boost term and saturated output.
	logic [W+2:0] adj;
	logic [W-1:0] full_cur, low_cur;
	logic [W+3:0] r_out;
	assign full_cur = ch_q ? full_r_q : full_l_q;
	assign low_cur = ch_q ? low_r_q : low_l_q;
	assign adj = (W+3)'(prod[W+30:28]) + (W+3)'(prod[27]);
	assign r_out = low_cur[W-1] ? ({{4{full_cur[W-1]}}, full_cur} - {1'b0, adj})
		: ({{4{full_cur[W-1]}}, full_cur} + {1'b0, adj});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fa_q <= tebu_pkg::FAST_ATTACK_RST;
			fr_q <= tebu_pkg::FAST_RELEASE_RST;
			sa_q <= tebu_pkg::SLOW_ATTACK_RST;
			sr_q <= tebu_pkg::SLOW_RELEASE_RST;
			mb_q <= tebu_pkg::MAX_BOOST_RST;
			for (int i = 0; i < 4; i++) env_q[i] <= '0;
			out_valid_q <= 1'b0;
			res_pend_q <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			k_q <= '0;
			ch_q <= 1'b0;
			n_q <= '0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;

			if (cfg_valid) begin
				case (tebu_pkg::cfg_idx_t'(cfg_index))
					tebu_pkg::CFG_FAST_ATTACK: fa_q <= cfg_data;
					tebu_pkg::CFG_FAST_RELEASE: fr_q <= cfg_data;
					tebu_pkg::CFG_SLOW_ATTACK: sa_q <= cfg_data;
					tebu_pkg::CFG_SLOW_RELEASE: sr_q <= cfg_data;
					tebu_pkg::CFG_MAX_BOOST: mb_q <= cfg_data[tebu_pkg::BOOST_W-1:0];
					default: ;
				endcase
			end

			// Output register: drain, then refill from a parked result.
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (res_pend_q && (!out_valid_q || !out_stall)) begin
				out_l_q <= res_l_q;
				out_r_q <= res_r_q;
				out_valid_q <= 1'b1;
				res_pend_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						full_l_q <= full_left;
						full_r_q <= full_right;
						low_l_q <= low_left;
						low_r_q <= low_right;
						if (mb_q == '0) begin
							res_l_q <= full_left;
							res_r_q <= full_right;
							res_pend_q <= 1'b1;
						end else begin
							k_q <= '0;
							state_q <= ST_ENV;
						end
					end
				end
				ST_ENV: begin
					up_q <= up_cur;
					mul_a_q <= AW'(up_cur ? (m_cur - e_cur) : (e_cur - m_cur));
					if (!k_q[1])
						mul_b_q <= BW'(up_cur ? fa_q : fr_q);
					else
						mul_b_q <= BW'(up_cur ? sa_q : sr_q);
					mul_go_q <= 1'b1;
					state_q <= ST_ENV_W;
				end
				ST_ENV_W: begin
					if (mul_st.done) begin
						env_q[k_q] <= up_q ? (e_cur + r_env) : (e_cur - r_env);
						k_q <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? ST_SUM : ST_ENV;
					end
				end
				ST_SUM: begin
					if (f_sum <= s_sum) begin
						gm1_q <= '0;
						ch_q <= 1'b0;
						state_q <= ST_BST;
					end else begin
						div_rem0_q <= DW'(num[NW-1:QW]);
						div_lo_q <= num[QW-1:0];
						div_dvsr_q <= den;
						div_go_q <= 1'b1;
						state_q <= ST_MASK_W;
					end
				end
				ST_MASK_W: begin
					if (div_st.done) begin
						mul_a_q <= AW'(quot[tebu_pkg::MASK_W-1:0]);
						mul_b_q <= BW'(mb_q);
						mul_go_q <= 1'b1;
						state_q <= ST_P_W;
					end
				end
				ST_P_W: begin
					if (mul_st.done) begin
						mul_a_q <= prod[AW-1:0];
						mul_b_q <= BW'(tebu_pkg::LN10_OVER_20_Q28);
						mul_go_q <= 1'b1;
						state_q <= ST_Y_W;
					end
				end
				ST_Y_W: begin
					if (mul_st.done) begin
						y_q <= prod[61:32] + YW'(prod[31]);
						mul_a_q <= AW'(tebu_pkg::ONE_Q28);
						mul_b_q <= BW'(prod[61:32] + YW'(prod[31]));
						mul_go_q <= 1'b1;
						gm1_q <= '0;
						n_q <= TW'(1);
						state_q <= ST_TM_W;
					end
				end
				ST_TM_W: begin
					if (mul_st.done) begin
						div_rem0_q <= '0;
						div_lo_q <= prod[57:28];
						div_dvsr_q <= DW'(n_q);
						div_go_q <= 1'b1;
						state_q <= ST_TD_W;
					end
				end
				ST_TD_W: begin
					if (div_st.done) begin
						gm1_q <= gm1_q + GW'(quot);
						if (n_q == TW'(tebu_pkg::SERIES_TERMS)) begin
							ch_q <= 1'b0;
							state_q <= ST_BST;
						end else begin
							n_q <= n_q + 1'b1;
							mul_a_q <= AW'(quot);
							mul_b_q <= BW'(y_q);
							mul_go_q <= 1'b1;
							state_q <= ST_TM_W;
						end
					end
				end
				ST_BST: begin
					// Wait until the previous result has left the parking slot.
					if (!res_pend_q) begin
						mul_a_q <= AW'(gm1_q);
						mul_b_q <= BW'(mag(low_cur));
						mul_go_q <= 1'b1;
						state_q <= ST_BST_W;
					end
				end
				ST_BST_W: begin
					if (mul_st.done) begin
						if (ch_q) begin
							res_r_q <= sat(r_out);
							res_pend_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							res_l_q <= sat(r_out);
							ch_q <= 1'b1;
							state_q <= ST_BST;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE) || res_pend_q;
	assign out_valid = out_valid_q;
	assign out_left = out_l_q;
	assign out_right = out_r_q;

	`TEBU_ASSERT_IMP(a_idle_units, clk, arst_n, state_q == ST_IDLE, !mul_st.busy && !div_st.busy)
	`TEBU_ASSERT_IMP(a_mask_range, clk, arst_n, div_st.done && (state_q == ST_MASK_W), quot <= QW'(tebu_pkg::MASK_ONE))
	`TEBU_ASSERT_IMP(a_env_bound, clk, arst_n, 1'b1, (env_q[0] <= ENV_MAX) && (env_q[1] <= ENV_MAX) && (env_q[2] <= ENV_MAX) && (env_q[3] <= ENV_MAX))
	`TEBU_ASSERT_NXT(a_result_moves, clk, arst_n, res_pend_q && (!out_valid_q || !out_stall), out_valid_q && !res_pend_q)
endmodule
